@@ sv/frt_pkg.sv @@
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

  localparam int SLOTS_DEFAULT        = 16;
  localparam int BUFFER_BYTES_DEFAULT = 1500;
  localparam int MAX_PARTS            = 8;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BAD_COUNT  = 3'd0,
    ST_BAD_INDEX  = 3'd1,
    ST_TABLE_FULL = 3'd2,
    ST_NOT_STORED = 3'd3,
    ST_STORED     = 3'd4,
    ST_COMPLETED  = 3'd5
  } status_code_t;

  // One table entry as kept in the slot memory
  typedef struct packed {
    logic [31:0] source;
    logic [15:0] frag_id;
    logic [7:0]  mask;
    logic [15:0] total;
    logic [15:0] tag;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic check;
    logic scan;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic scan_done;
  } sts_t;

endpackage

@@ sv/frt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/frt_datapath.sv @@
// Datapath: request registers, slot table, scan, and result formation.
module frt_datapath #(
  parameter int SLOTS        = frt_pkg::SLOTS_DEFAULT,
  parameter int BUFFER_BYTES = frt_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  frt_pkg::cmd_t  cmd,
  output frt_pkg::sts_t  sts,
  input  logic [31:0]    source_address,
  input  logic [15:0]    fragment_id,
  input  logic [7:0]     part_index,
  input  logic [7:0]     part_count,
  input  logic [15:0]    part_length,
  input  logic [15:0]    part_stride,
  output logic [2:0]     status,
  output logic [3:0]     slot,
  output logic [10:0]    write_offset,
  output logic [15:0]    local_tag,
  output logic [15:0]    total_length
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = IW + 1;
  localparam int EW = $bits(frt_pkg::entry_t);

  // Request registers
  logic [31:0] src_r;
  logic [15:0] id_r;
  logic [7:0]  idx_r;
  logic [7:0]  cnt_r;
  logic [15:0] len_r;
  logic [15:0] stride_r;
  logic [23:0] off_r;
  logic [23:0] span_r;

  // Check results
  logic        fit;
  logic [15:0] total_new;

  // Scan state
  logic [CW-1:0] rd_idx;
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;
  logic          found_match;
  logic          found_free;
  logic [IW-1:0] match_idx;
  logic [IW-1:0] free_idx;
  frt_pkg::entry_t match_ent;
  logic [15:0]   free_total;

  // Table state
  logic [SLOTS-1:0] used;
  logic [15:0]      next_tag;

  // Memory ports
  frt_pkg::entry_t ram_q;
  frt_pkg::entry_t ram_wdata;
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_rdata;

  // Combinational decision
  logic          bad_count;
  logic          bad_index;
  logic          issue;
  logic          hit_now;
  logic          last_cmp;
  logic          valid_req;
  logic          have_slot;
  logic          claim;
  logic [IW-1:0] s_idx;
  logic [7:0]    old_mask;
  logic [15:0]   old_total;
  logic [15:0]   cur_tag;
  logic [7:0]    new_mask;
  logic [7:0]    full_mask;
  logic          is_last;
  logic [15:0]   total_upd;
  logic          complete;
  logic [IW+3:0] slot_ext;
  frt_pkg::status_code_t res_status;

  assign ram_q = frt_pkg::entry_t'(ram_rdata);

  // Header sanity
  assign bad_count = (cnt_r == 8'd0) || (cnt_r > 8'(frt_pkg::MAX_PARTS));
  assign bad_index = (idx_r >= cnt_r);
  assign sts.bad   = bad_count || bad_index;

  // Scan compare, one slot per cycle behind the read
  assign issue    = cmd.scan && (rd_idx < CW'(SLOTS));
  assign hit_now  = cmd.scan && cmp_vld && used[cmp_idx] &&
                    (ram_q.source == src_r) && (ram_q.frag_id == id_r);
  assign last_cmp = cmd.scan && cmp_vld && (cmp_idx == IW'(SLOTS - 1));
  assign sts.scan_done = hit_now || last_cmp;

  // Slot selection, mask update and result status
  always_comb begin
    valid_req = !bad_count && !bad_index;
    have_slot = found_match || found_free;
    claim     = !found_match && found_free;
    s_idx     = found_match ? match_idx : free_idx;
    old_mask  = found_match ? match_ent.mask : 8'd0;
    old_total = found_match ? match_ent.total : free_total;
    cur_tag   = found_match ? match_ent.tag : next_tag;
    new_mask  = old_mask | (8'd1 << idx_r[2:0]);
    full_mask = 8'((9'd1 << cnt_r) - 9'd1);
    is_last   = (idx_r == (cnt_r - 8'd1));
    total_upd = is_last ? total_new : old_total;
    complete  = (new_mask == full_mask);
    slot_ext  = {4'd0, s_idx};
    if (bad_count) begin
      res_status = frt_pkg::ST_BAD_COUNT;
    end else if (bad_index) begin
      res_status = frt_pkg::ST_BAD_INDEX;
    end else if (!have_slot) begin
      res_status = frt_pkg::ST_TABLE_FULL;
    end else if (!fit) begin
      res_status = frt_pkg::ST_NOT_STORED;
    end else if (complete) begin
      res_status = frt_pkg::ST_COMPLETED;
    end else begin
      res_status = frt_pkg::ST_STORED;
    end
  end

  // Table write: stored parts, and claims that did not fit
  always_comb begin
    ram_we    = cmd.commit && valid_req && have_slot && (fit || claim);
    ram_waddr = s_idx;
    ram_wdata.source  = src_r;
    ram_wdata.frag_id = id_r;
    ram_wdata.tag     = cur_tag;
    ram_wdata.mask    = fit ? new_mask : 8'd0;
    ram_wdata.total   = fit ? total_upd : old_total;
  end

  frt_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Capture request, offset and span products; latch check results and scan hits
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      src_r    <= source_address;
      id_r     <= fragment_id;
      idx_r    <= part_index;
      cnt_r    <= part_count;
      len_r    <= part_length;
      stride_r <= part_stride;
      off_r    <= {8'd0, part_stride} * {16'd0, part_index};
      span_r   <= {8'd0, part_stride} * {16'd0, part_count - 8'd1};
    end
    if (cmd.check) begin
      fit       <= (stride_r != 16'd0) &&
                   (({1'b0, off_r} + {9'd0, len_r}) <= 25'(BUFFER_BYTES));
      total_new <= 16'(span_r + {8'd0, len_r});
    end
    if (cmd.scan && hit_now) begin
      match_idx <= cmp_idx;
      match_ent <= ram_q;
    end
    if (cmd.scan && cmp_vld && !used[cmp_idx] && !found_free) begin
      free_idx   <= cmp_idx;
      free_total <= ram_q.total;
    end
    if (cmd.scan) begin
      cmp_idx <= rd_idx[IW-1:0];
    end
  end

  // Scan control and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx      <= '0;
      cmp_vld     <= 1'b0;
      found_match <= 1'b0;
      found_free  <= 1'b0;
      used        <= '0;
      next_tag    <= 16'd0;
    end else begin
      if (cmd.check) begin
        rd_idx      <= '0;
        cmp_vld     <= 1'b0;
        found_match <= 1'b0;
        found_free  <= 1'b0;
      end
      if (cmd.scan) begin
        cmp_vld <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CW'(1);
        end
        if (hit_now) begin
          found_match <= 1'b1;
        end
        if (cmp_vld && !used[cmp_idx]) begin
          found_free <= 1'b1;
        end
      end
      if (cmd.commit && valid_req && have_slot) begin
        if (fit && complete) begin
          used[s_idx] <= 1'b0;
        end else if (claim) begin
          used[s_idx] <= 1'b1;
        end
        if (claim) begin
          next_tag <= next_tag + 16'd1;
        end
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status       <= res_status;
      slot         <= (res_status >= frt_pkg::ST_NOT_STORED) ? slot_ext[3:0] : 4'd0;
      write_offset <= (res_status >= frt_pkg::ST_STORED) ? off_r[10:0] : 11'd0;
      local_tag    <= (res_status >= frt_pkg::ST_NOT_STORED) ? cur_tag : 16'd0;
      total_length <= (res_status == frt_pkg::ST_COMPLETED) ? total_upd : 16'd0;
    end
  end

endmodule

@@ sv/frt_ctrl.sv @@
// Controller: sequences check, table scan (skipped for bad requests) and commit for each request.
module frt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output frt_pkg::cmd_t cmd,
  input  frt_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Commands
  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.check   = (state == S_CHECK);
  assign cmd.scan    = (state == S_SCAN);
  assign cmd.commit  = (state == S_FINISH) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = sts.bad ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/fragment_reassembly_tracker.sv @@
// Top level of the fragment reassembly tracker: controller plus datapath.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    source_address fragment_id part_index
//                                           part_count part_length part_stride
// out       output     out_valid/out_ready  status slot write_offset local_tag
//                                           total_length
//
// A request with a bad count or index skips the table scan and goes from check
// straight to finish. Others scan the table memory one slot per cycle through
// its single read port, stopping at the first matching slot.
// Reset clears the used flags and the tag counter.
// A finished result waits in the output register; a new request is taken
// while it waits, and is held in its final state until the register frees.
module fragment_reassembly_tracker #(
  parameter int SLOTS        = frt_pkg::SLOTS_DEFAULT,
  parameter int BUFFER_BYTES = frt_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] source_address,
  input  logic [15:0] fragment_id,
  input  logic [7:0]  part_index,
  input  logic [7:0]  part_count,
  input  logic [15:0] part_length,
  input  logic [15:0] part_stride,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [3:0]  slot,
  output logic [10:0] write_offset,
  output logic [15:0] local_tag,
  output logic [15:0] total_length
);

  frt_pkg::cmd_t cmd;
  frt_pkg::sts_t sts;

  frt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  frt_datapath #(
    .SLOTS        (SLOTS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .source_address (source_address),
    .fragment_id    (fragment_id),
    .part_index     (part_index),
    .part_count     (part_count),
    .part_length    (part_length),
    .part_stride    (part_stride),
    .status         (status),
    .slot           (slot),
    .write_offset   (write_offset),
    .local_tag      (local_tag),
    .total_length   (total_length)
  );

endmodule

@@ sv/frt_checker.sv @@
// Port-level checker for the fragment reassembly tracker, with its bind.
module frt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [3:0]  slot,
  input logic [10:0] write_offset,
  input logic [15:0] local_tag,
  input logic [15:0] total_length
);

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= frt_pkg::ST_COMPLETED))
    else $error("status code out of range");

  // Rejected requests carry no slot, tag or offset
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status <= frt_pkg::ST_TABLE_FULL) |->
      (slot == 4'd0 && local_tag == 16'd0 && write_offset == 11'd0))
    else $error("rejected request carries slot data");

  // Total length only on completion
  a_total_only_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != frt_pkg::ST_COMPLETED) |-> (total_length == 16'd0))
    else $error("total length outside completion");

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(slot)))
    else $error("stalled result changed");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (.*);
